### design/sbb_pkg.sv
// Shared widths, register indexes, reset values and action codes for the spectrum meter.
package sbb_pkg;

    localparam int LEVEL_W    = 14;
    localparam int BIN_W      = 9;
    localparam int DECAY_W    = 16;
    localparam int HOLD_CFG_W = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [LEVEL_W-1:0] t_level;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PK_EN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 3'd4;

    // register reset values
    localparam logic [DECAY_W-1:0]    RST_DECAY   = 16'd52429;
    localparam logic [HOLD_CFG_W-1:0] RST_HOLD    = 10'd60;
    localparam logic                  RST_PK_EN   = 1'b1;
    localparam t_level                RST_FLOOR   = -14'sd5760;
    localparam t_level                RST_CEILING = 14'sd0;

    // 0.95 in Q0.16
    localparam logic [DECAY_W-1:0] PEAK_DECAY_Q16 = 16'd62259;

    // action codes
    localparam logic ACT_LEVEL = 1'b0;
    localparam logic ACT_IDLE  = 1'b1;

endpackage

### design/sbb_in_if.sv
// Input channel: one bin level or idle tick per beat.
interface sbb_in_if import sbb_pkg::*;;
    logic                valid;
    logic                ready;
    logic                action;
    logic [BIN_W-1:0]    bin_index;
    logic signed [LEVEL_W-1:0] level_db;

    modport source (output valid, output action, output bin_index, output level_db,
                    input ready);
    modport sink   (input valid, input action, input bin_index, input level_db,
                    output ready);
endinterface

### design/sbb_out_if.sv
// Output channel: updated smoothed level and peak for one bin per beat.
interface sbb_out_if import sbb_pkg::*;;
    logic                valid;
    logic                ready;
    logic [BIN_W-1:0]    bin_out;
    logic signed [LEVEL_W-1:0] smoothed_db;
    logic signed [LEVEL_W-1:0] peak_db;

    modport source (output valid, output bin_out, output smoothed_db, output peak_db,
                    input ready);
    modport sink   (input valid, input bin_out, input smoothed_db, input peak_db,
                    output ready);
endinterface

### design/spectrum_bin_ballistics_peak_hold_core.sv
// Per-bin spectrum meter: attack/decay smoothing and peak hold, state in one bin memory.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------
//  i_in     | in  | valid/ready   | action, bin_index, level_db
//  o_out    | out | valid/ready   | bin_out, smoothed_db, peak_db
//  i_cfg_*  | in  | write enable  | i_cfg_idx, i_cfg_data
//
// One beat per cycle unless the output stalls, a same-bin hazard holds or clearing runs;
// o_out.valid follows the memory read stage, the multiply stage, then the output register.
// A second beat on the same bin as the one in stage 1 stalls until that one moves on; it
// then reads as the first is written and takes its result from the last-write register.
// After reset a clearing pass writes every bin with i_in.ready low.
// An output stall freezes the whole pipeline; the output register holds its beat.
module spectrum_bin_ballistics_peak_hold_core import sbb_pkg::*; #(
    parameter int BINS      = 512,
    parameter int HOLD_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sbb_in_if.sink                i_in,
    sbb_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW       = $clog2(BINS);
    localparam int EW       = (AW > BIN_W) ? AW : BIN_W;
    localparam int HOLD_MAX = (1 << HOLD_BITS) - 1;
    localparam int PROD_W   = LEVEL_W + DECAY_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(BINS - 1);

    typedef struct packed {
        t_level                sm;
        t_level                pk;
        logic [HOLD_BITS-1:0]  hc;
    } t_entry;

    // configuration
    logic [DECAY_W-1:0]    r_decay;
    logic [HOLD_CFG_W-1:0] r_hold;
    logic                  r_pk_en;
    t_level                r_floor;
    t_level                r_ceiling;

    // memory and clearing pass
    t_entry                r_mem [BINS];
    t_entry                r_rd;
    logic                  r_clr_active;
    logic [AW-1:0]         r_clr_addr;

    // last item write, for the read that coincides with it
    logic                  r_lw_valid;
    logic [AW-1:0]         r_lw_addr;
    t_entry                r_lw;

    // stage 1: read data available
    logic                  r_s1_valid;
    logic                  r_s1_in_range;
    logic [BIN_W-1:0]      r_s1_bin;
    logic [AW-1:0]         r_s1_addr;
    logic                  r_s1_action;
    t_level                r_s1_level;

    // stage 2: products registered
    logic                  r_s2_valid;
    logic                  r_s2_in_range;
    logic [BIN_W-1:0]      r_s2_bin;
    logic [AW-1:0]         r_s2_addr;
    t_level                r_s2_target;
    logic                  r_s2_rise;
    logic                  r_s2_neg;
    logic [LEVEL_W-1:0]    r_s2_q;
    t_level                r_s2_pk;
    logic [HOLD_BITS-1:0]  r_s2_hc;
    logic                  r_s2_pneg;
    logic [LEVEL_W-1:0]    r_s2_pq;

    // output register
    logic                  r_out_valid;
    logic [BIN_W-1:0]      r_out_bin;
    t_level                r_out_sm;
    t_level                r_out_pk;

    logic                  advance;
    logic                  hazard;
    logic                  in_acc;
    logic                  in_range;
    logic [EW-1:0]         bin_ext;
    logic [AW-1:0]         in_addr;
    t_level                lv_clamped;

    logic                  fwd;
    t_entry                s1_ent;
    t_level                s1_target;
    logic                  s1_rise;
    logic signed [LEVEL_W:0] s1_diff;
    logic signed [LEVEL_W:0] s1_pdiff;
    logic [LEVEL_W:0]      s1_mag;
    logic [LEVEL_W:0]      s1_pmag;
    logic [PROD_W-1:0]     s1_prod;
    logic [PROD_W-1:0]     s1_pprod;

    logic [LEVEL_W:0]      s2_sum;
    logic [LEVEL_W:0]      s2_psum;
    t_level                s2_sm;
    t_level                s2_pk_dec;
    t_level                s2_npk;
    logic [HOLD_BITS-1:0]  s2_nhc;
    logic [HOLD_BITS-1:0]  hold_load;
    logic                  item_we;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    t_entry                mem_wdata;

    // ---------------- handshake ----------------
    assign advance    = !r_out_valid || o_out.ready;
    assign hazard     = r_s1_valid && (r_s1_bin == i_in.bin_index);
    assign i_in.ready = advance && !r_clr_active && !hazard;
    assign in_acc     = i_in.valid && i_in.ready;

    assign bin_ext  = EW'(i_in.bin_index);
    assign in_addr  = bin_ext[AW-1:0];
    assign in_range = 32'(i_in.bin_index) < BINS;

    always_comb begin
        lv_clamped = i_in.level_db;
        if (lv_clamped < r_floor) lv_clamped = r_floor;
        if (lv_clamped > r_ceiling) lv_clamped = r_ceiling;
    end

    // ---------------- stage 1: operands and multiplies ----------------
    assign fwd    = r_lw_valid && (r_lw_addr == r_s1_addr);
    assign s1_ent = fwd ? r_lw : r_rd;

    always_comb begin
        s1_target = (r_s1_action == ACT_IDLE) ? r_floor : r_s1_level;
        s1_rise   = (r_s1_action == ACT_LEVEL) && (r_s1_level > s1_ent.sm);
        s1_diff   = {s1_ent.sm[LEVEL_W-1], s1_ent.sm} - {s1_target[LEVEL_W-1], s1_target};
        s1_pdiff  = {s1_ent.pk[LEVEL_W-1], s1_ent.pk} - {r_floor[LEVEL_W-1], r_floor};
        s1_mag    = s1_diff[LEVEL_W] ? (LEVEL_W+1)'(-s1_diff) : s1_diff;
        s1_pmag   = s1_pdiff[LEVEL_W] ? (LEVEL_W+1)'(-s1_pdiff) : s1_pdiff;
        s1_prod   = PROD_W'(s1_mag[LEVEL_W-1:0]) * PROD_W'(r_decay);
        s1_pprod  = PROD_W'(s1_pmag[LEVEL_W-1:0]) * PROD_W'(PEAK_DECAY_Q16);
    end

    // ---------------- stage 2: finish blends, peak hold ----------------
    assign hold_load = (32'(r_hold) > HOLD_MAX) ? HOLD_BITS'(HOLD_MAX)
                                                : HOLD_BITS'(r_hold);

    always_comb begin
        s2_sum  = r_s2_neg ? ({r_s2_target[LEVEL_W-1], r_s2_target} - {1'b0, r_s2_q})
                           : ({r_s2_target[LEVEL_W-1], r_s2_target} + {1'b0, r_s2_q});
        s2_psum = r_s2_pneg ? ({r_floor[LEVEL_W-1], r_floor} - {1'b0, r_s2_pq})
                            : ({r_floor[LEVEL_W-1], r_floor} + {1'b0, r_s2_pq});
        s2_sm     = r_s2_rise ? r_s2_target : s2_sum[LEVEL_W-1:0];
        s2_pk_dec = s2_psum[LEVEL_W-1:0];
        if (s2_pk_dec < r_floor) s2_pk_dec = r_floor;

        s2_npk = r_s2_pk;
        s2_nhc = r_s2_hc;
        if (r_pk_en) begin
            if (s2_sm >= r_s2_pk) begin
                s2_npk = s2_sm;
                s2_nhc = hold_load;
            end else if (r_s2_hc != '0) begin
                s2_nhc = r_s2_hc - 1'b1;
            end else begin
                s2_npk = s2_pk_dec;
            end
        end
    end

    assign item_we   = advance && r_s2_valid && r_s2_in_range;
    assign mem_we    = r_clr_active || item_we;
    assign mem_waddr = r_clr_active ? r_clr_addr : r_s2_addr;
    assign mem_wdata = r_clr_active ? t_entry'{RST_FLOOR, RST_FLOOR, '0}
                                    : t_entry'{s2_sm, s2_npk, s2_nhc};

    // ---------------- memory ----------------
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (in_acc) r_rd <= r_mem[in_addr];
    end

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay      <= RST_DECAY;
            r_hold       <= RST_HOLD;
            r_pk_en      <= RST_PK_EN;
            r_floor      <= RST_FLOOR;
            r_ceiling    <= RST_CEILING;
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_lw_valid   <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DECAY:   r_decay   <= i_cfg_data[DECAY_W-1:0];
                    CFG_HOLD:    r_hold    <= i_cfg_data[HOLD_CFG_W-1:0];
                    CFG_PK_EN:   r_pk_en   <= i_cfg_data[0];
                    CFG_FLOOR:   r_floor   <= i_cfg_data[LEVEL_W-1:0];
                    CFG_CEILING: r_ceiling <= i_cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) r_clr_active <= 1'b0;
            end
            if (item_we) r_lw_valid <= 1'b1;
            if (advance) begin
                r_s1_valid  <= in_acc;
                r_s2_valid  <= r_s1_valid;
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge i_clk) begin
        if (item_we) begin
            r_lw_addr <= r_s2_addr;
            r_lw      <= t_entry'{s2_sm, s2_npk, s2_nhc};
        end
        if (advance) begin
            r_s1_in_range <= in_range;
            r_s1_bin      <= i_in.bin_index;
            r_s1_addr     <= in_addr;
            r_s1_action   <= i_in.action;
            r_s1_level    <= lv_clamped;

            r_s2_in_range <= r_s1_in_range;
            r_s2_bin      <= r_s1_bin;
            r_s2_addr     <= r_s1_addr;
            r_s2_target   <= s1_target;
            r_s2_rise     <= s1_rise;
            r_s2_neg      <= s1_diff[LEVEL_W];
            r_s2_q        <= s1_prod[PROD_W-1:DECAY_W];
            r_s2_pk       <= s1_ent.pk;
            r_s2_hc       <= s1_ent.hc;
            r_s2_pneg     <= s1_pdiff[LEVEL_W];
            r_s2_pq       <= s1_pprod[PROD_W-1:DECAY_W];

            r_out_bin     <= r_s2_bin;
            r_out_sm      <= r_s2_in_range ? s2_sm : '0;
            r_out_pk      <= r_s2_in_range ? s2_npk : '0;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.bin_out     = r_out_bin;
    assign o_out.smoothed_db = r_out_sm;
    assign o_out.peak_db     = r_out_pk;

endmodule

### design/sbb_checker.sv
// Port-level checks for the spectrum meter core, bound to the top level.
module sbb_checker import sbb_pkg::*; #(
    parameter int BINS = 512
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [BIN_W-1:0]          i_out_bin,
    input logic signed [LEVEL_W-1:0] i_out_sm,
    input logic signed [LEVEL_W-1:0] i_out_pk
);

    logic [2:0] r_inflight;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 3'(in_acc) - 3'(out_acc);
        end
    end

    // pipeline holds at most three beats
    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 3'd3)
        else $error("more than three beats in flight");

    // no result without an accepted input
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_inflight != 3'd0)
        else $error("result without pending input");

    // out-of-range bins report zero levels
    a_oob_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (32'(i_out_bin) >= BINS)) |-> (i_out_sm == '0 && i_out_pk == '0))
        else $error("out-of-range bin with nonzero levels");

    // clearing pass keeps input closed right after reset
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_in_ready)
        else $error("input ready during clearing pass");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_bin) && $stable(i_out_sm) && $stable(i_out_pk)))
        else $error("stalled result changed");

endmodule

bind spectrum_bin_ballistics_peak_hold_core sbb_checker #(.BINS(BINS)) u_sbb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_bin   (o_out.bin_out),
    .i_out_sm    (o_out.smoothed_db),
    .i_out_pk    (o_out.peak_db)
);
